FILE: hw/rtl/wso_pkg.sv
// ----------------------------------------------------------------------------
// wso_pkg
// Shared widths, constants and types for the wheel speed / odometer block.
// ----------------------------------------------------------------------------
`default_nettype none

package wso_pkg;

  localparam int TS_W       = 32;  // timestamp and elapsed time
  localparam int TIMER_BITS = 32;  // bits of the free-running timer in use
  localparam int DPP_W      = 24;  // distance per pulse
  localparam int DIST_W     = 48;  // distance total
  localparam int SPEED_W    = 36;  // speed result
  localparam int SPH_W      = 12;  // width of the seconds-per-hour constant
  localparam int DIVIDEND_W = DPP_W + SPH_W;
  localparam int DIVISOR_W  = TS_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [SPH_W-1:0]   SECONDS_PER_HOUR = SPH_W'(3600);
  localparam logic [DPP_W-1:0]   DPP_RESET        = DPP_W'(2100000);
  localparam logic [DIST_W-1:0]  DIST_MAX         = {DIST_W{1'b1}};
  localparam logic [SPEED_W-1:0] SPEED_MAX        = {SPEED_W{1'b1}};
  localparam logic [TS_W-1:0]    TIMER_MASK       =
    TS_W'((64'd1 << TIMER_BITS) - 64'd1);

  // word index of each register on the configuration port
  localparam logic [APB_ADDR_W-3:0] REG_DPP = '0;

  localparam logic FUNC_PULSE = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } wso_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wso_div.sv
// ----------------------------------------------------------------------------
// wso_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wso_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [wso_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [wso_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                  done,
  output logic [wso_pkg::DIVIDEND_W-1:0]        quotient
);

  logic                             busy;
  logic [wso_pkg::DIV_CNT_W-1:0]    count;
  logic [wso_pkg::DIVIDEND_W-1:0]   q;
  logic [wso_pkg::DIVISOR_W-1:0]    d;
  logic [wso_pkg::DIVISOR_W:0]      r;
  logic [wso_pkg::DIVISOR_W:0]      r_shift;
  logic [wso_pkg::DIVISOR_W+1:0]    diff;

  // partial remainder stays below the divisor, so one extra bit holds the shift
  assign r_shift = {r[wso_pkg::DIVISOR_W-1:0], q[wso_pkg::DIVIDEND_W-1]};
  assign diff    = {1'b0, r_shift} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= wso_pkg::DIV_CNT_W'(wso_pkg::DIVIDEND_W - 1);
      q     <= dividend;
      d     <= divisor;
      r     <= '0;
    end else if (busy) begin
      count <= count - 1'b1;
      if (!diff[wso_pkg::DIVISOR_W+1]) begin
        r <= diff[wso_pkg::DIVISOR_W:0];
        q <= {q[wso_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        r <= r_shift;
        q <= {q[wso_pkg::DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = q;

endmodule

`default_nettype wire

FILE: hw/rtl/wheel_speed_odometer.sv
// ----------------------------------------------------------------------------
// wheel_speed_odometer
// Hall-sensor wheel speedometer and odometer: distance, elapsed time and
// speed in m/h from timestamped pulse and clear events.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------
//   pulse    | pulse_valid / pulse_stall   | func, timestamp_us
//   result   | result_valid / result_stall | distance_um, speed_m_per_h,
//            |                             | elapsed_us, zero_interval
//   config   | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// A pulse with a nonzero interval passes through ST_DIV, then ST_LOAD:
// the speed divider retires one quotient bit per cycle over 36 bits.
// Clear and zero-interval pulses go to ST_LOAD. One item is in work at a time;
// a finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous) zeroes the totals and loads the default distance
// per pulse; result_stall holds a full output register and the ST_LOAD state.
`default_nettype none

module wheel_speed_odometer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // pulse channel
  input  wire logic                              pulse_valid,
  output logic                                   pulse_stall,
  input  wire logic                              func,
  input  wire logic [wso_pkg::TS_W-1:0]          timestamp_us,
  // result channel
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic [wso_pkg::DIST_W-1:0]             distance_um,
  output logic [wso_pkg::SPEED_W-1:0]            speed_m_per_h,
  output logic [wso_pkg::TS_W-1:0]               elapsed_us,
  output logic                                   zero_interval,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [wso_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [wso_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [wso_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  wso_pkg::wso_state_t              state, state_next;

  logic [wso_pkg::DPP_W-1:0]        dist_per_pulse;
  logic [wso_pkg::TS_W-1:0]         last_pulse_time;
  logic [wso_pkg::DIST_W-1:0]       distance_total;
  logic [wso_pkg::TS_W-1:0]         elapsed_total;
  logic [wso_pkg::SPEED_W-1:0]      speed;
  logic                             zero_flag;

  logic                             take;
  logic                             div_start;
  logic                             div_done;
  logic                             load_out;
  logic                             cfg_write;
  logic [wso_pkg::TS_W-1:0]         ts;
  logic [wso_pkg::TS_W-1:0]         interval;
  logic [wso_pkg::DIST_W:0]         dist_sum;
  logic [wso_pkg::DIVIDEND_W-1:0]   product;
  logic [wso_pkg::DIVIDEND_W-1:0]   quotient;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     paddr[wso_pkg::APB_ADDR_W-1:2] == wso_pkg::REG_DPP;

  always_comb begin
    prdata = '0;
    if (paddr[wso_pkg::APB_ADDR_W-1:2] == wso_pkg::REG_DPP) begin
      prdata = wso_pkg::APB_DATA_W'(dist_per_pulse);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_pulse <= wso_pkg::DPP_RESET;
    end else if (cfg_write) begin
      dist_per_pulse <= pwdata[wso_pkg::DPP_W-1:0];
    end
  end

  // ---------------- per-transfer arithmetic ----------------
  assign take     = pulse_valid && !pulse_stall;
  assign ts       = timestamp_us & wso_pkg::TIMER_MASK;
  assign interval = (ts - last_pulse_time) & wso_pkg::TIMER_MASK;
  assign dist_sum = {1'b0, distance_total} + (wso_pkg::DIST_W + 1)'(dist_per_pulse);
  assign product  = wso_pkg::DIVIDEND_W'(dist_per_pulse) *
                    wso_pkg::DIVIDEND_W'(wso_pkg::SECONDS_PER_HOUR);
  assign div_start = take && func == wso_pkg::FUNC_PULSE && interval != '0;

  wso_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (interval),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wso_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pulse_stall = 1'b1;
    load_out    = 1'b0;
    unique case (state)
      wso_pkg::ST_IDLE: begin
        pulse_stall = 1'b0;
        if (pulse_valid) begin
          state_next = div_start ? wso_pkg::ST_DIV : wso_pkg::ST_LOAD;
        end
      end
      wso_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = wso_pkg::ST_LOAD;
        end
      end
      wso_pkg::ST_LOAD: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = wso_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wso_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------- totals ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time <= '0;
      distance_total  <= '0;
      elapsed_total   <= '0;
    end else if (take) begin
      last_pulse_time <= ts;
      if (func == wso_pkg::FUNC_CLEAR) begin
        distance_total <= '0;
        elapsed_total  <= '0;
      end else begin
        elapsed_total  <= elapsed_total + interval;
        distance_total <= dist_sum[wso_pkg::DIST_W] ? wso_pkg::DIST_MAX :
                          dist_sum[wso_pkg::DIST_W-1:0];
      end
    end
  end

  // speed of the item in work; the quotient always fits in 36 bits
  always_ff @(posedge clk) begin
    if (take) begin
      if (func == wso_pkg::FUNC_CLEAR) begin
        speed     <= '0;
        zero_flag <= 1'b0;
      end else begin
        speed     <= wso_pkg::SPEED_MAX;
        zero_flag <= (interval == '0);
      end
    end else if (state == wso_pkg::ST_DIV && div_done) begin
      speed <= quotient[wso_pkg::SPEED_W-1:0];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      distance_um   <= distance_total;
      speed_m_per_h <= speed;
      elapsed_us    <= elapsed_total;
      zero_interval <= zero_flag;
    end
  end

endmodule

`default_nettype wire
